>>> rtl/rrf_pkg.sv
// shared types, codes and defaults of the resizable ring fifo
`default_nettype none

package rrf_pkg;

  // default build sizes
  localparam int DEF_MAX_DEPTH    = 64;
  localparam int DEF_HANDLE_WIDTH = 32;
  localparam int INIT_CAPACITY    = 8;

  // fixed port widths
  localparam int FUNC_W   = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 7;
  localparam int TOTAL_W  = 32;

  // command codes
  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 2'd0,
    FN_POP    = 2'd1,
    FN_GROW   = 2'd2,
    FN_SHRINK = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_AT_MAX   = 3'd3,
    STAT_AT_MIN   = 3'd4,
    STAT_TOO_MANY = 3'd5
  } status_e;

  // commands from controller to datapath
  typedef struct packed {
    logic    push;       // store word at tail
    logic    pop;        // remove word at head
    logic    copy_init;  // load copy pointers from head
    logic    copy_rd;    // read one entry of the active bank for compaction
    logic    commit;     // finish a resize: swap banks, rebase pointers
    logic    grow;       // resize direction at commit
    logic    emit;       // load result registers and strobe done
    status_e status;     // status code of the result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic at_max;
    logic at_min;
    logic too_many;
    logic copy_last;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/resizable_ring_fifo_unit.sv
// top level of the resizable ring fifo of message handles
//
// Usage: raise start with func_i and push_data_i while busy is low; the
// command is taken at that clock edge. Commands: push, pop, grow capacity
// by one, shrink capacity by one. Each command gives exactly one result
// word, shown on the result ports for one cycle with done_o high.
// Push, pop and every refused command: the result follows in the cycle
// after the command is taken and busy stays low, so one command per cycle.
// Grow and shrink copy the held entries, head first, into the second bank
// of the store, one entry per cycle through its single read port: busy is
// high through the copy and after-commit states, and the result is
// registered at the commit that swaps the banks.
// Reset: queue empty, capacity 8 (or the build depth if smaller), totals
// zero; store contents are undefined and never returned.
// The receiver takes every result in its strobe cycle and cannot stall.
`default_nettype none

module resizable_ring_fifo_unit #(
  parameter int MAX_DEPTH    = rrf_pkg::DEF_MAX_DEPTH,
  parameter int HANDLE_WIDTH = rrf_pkg::DEF_HANDLE_WIDTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [rrf_pkg::FUNC_W-1:0]    func_i,
  input  wire logic [rrf_pkg::DATA_W-1:0]    push_data_i,
  output      logic                          done_o,
  output      logic [rrf_pkg::DATA_W-1:0]    pop_data_o,
  output      logic [rrf_pkg::STATUS_W-1:0]  status_o,
  output      logic [rrf_pkg::COUNT_W-1:0]   item_count_o,
  output      logic [rrf_pkg::COUNT_W-1:0]   cur_capacity_o,
  output      logic [rrf_pkg::TOTAL_W-1:0]   added_total_o,
  output      logic [rrf_pkg::TOTAL_W-1:0]   removed_total_o
);

  rrf_pkg::cmd_t cmd;
  rrf_pkg::sts_t sts;

  // command sequencer
  rrf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // store and counters
  rrf_dpath #(
    .MAX_DEPTH    (MAX_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .push_data_i     (push_data_i),
    .sts_o           (sts),
    .done_o          (done_o),
    .pop_data_o      (pop_data_o),
    .status_o        (status_o),
    .item_count_o    (item_count_o),
    .cur_capacity_o  (cur_capacity_o),
    .added_total_o   (added_total_o),
    .removed_total_o (removed_total_o)
  );

endmodule

`default_nettype wire

>>> rtl/rrf_ram.sv
// generic single write, single registered read port ram
`default_nettype none

module rrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, and read returning the old contents on a collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/rrf_ctrl.sv
// command sequencer of the resizable ring fifo
`default_nettype none

module rrf_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  input  wire logic [rrf_pkg::FUNC_W-1:0]    func_i,
  input  wire rrf_pkg::sts_t                 sts_i,
  output      rrf_pkg::cmd_t                 cmd_o,
  output      logic                          busy
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_COPY = 3'b010,
    S_PREF = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   grow_q, grow_d;
  rrf_pkg::func_e func;

  assign func = rrf_pkg::func_e'(func_i);
  assign busy = (state_q != S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    grow_d  = grow_q;
    cmd_o   = '0;
    cmd_o.status = rrf_pkg::STAT_OK;
    cmd_o.grow   = grow_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (func)
            rrf_pkg::FN_PUSH: begin
              cmd_o.emit = 1'b1;
              if (sts_i.full) begin
                cmd_o.status = rrf_pkg::STAT_FULL;
              end else begin
                cmd_o.push = 1'b1;
              end
            end
            rrf_pkg::FN_POP: begin
              cmd_o.emit = 1'b1;
              if (sts_i.empty) begin
                cmd_o.status = rrf_pkg::STAT_EMPTY;
              end else begin
                cmd_o.pop = 1'b1;
              end
            end
            rrf_pkg::FN_GROW: begin
              if (sts_i.at_max) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = rrf_pkg::STAT_AT_MAX;
              end else begin
                cmd_o.copy_init = 1'b1;
                grow_d  = 1'b1;
                state_d = S_COPY;
              end
            end
            rrf_pkg::FN_SHRINK: begin
              if (sts_i.at_min) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = rrf_pkg::STAT_AT_MIN;
              end else if (sts_i.too_many) begin
                cmd_o.emit   = 1'b1;
                cmd_o.status = rrf_pkg::STAT_TOO_MANY;
              end else begin
                cmd_o.copy_init = 1'b1;
                grow_d  = 1'b0;
                state_d = S_COPY;
              end
            end
            default: ;
          endcase
        end
      end
      S_COPY: begin
        if (sts_i.copy_last) begin
          cmd_o.commit = 1'b1;
          cmd_o.emit   = 1'b1;
          state_d      = S_PREF;
        end else begin
          cmd_o.copy_rd = 1'b1;
        end
      end
      S_PREF: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      grow_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      grow_q  <= grow_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rrf_dpath.sv
// pointers, counters, two-bank store and result registers of the ring fifo
`default_nettype none

module rrf_dpath #(
  parameter int MAX_DEPTH    = rrf_pkg::DEF_MAX_DEPTH,
  parameter int HANDLE_WIDTH = rrf_pkg::DEF_HANDLE_WIDTH
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire rrf_pkg::cmd_t                  cmd_i,
  input  wire logic [rrf_pkg::DATA_W-1:0]     push_data_i,
  output      rrf_pkg::sts_t                  sts_o,
  output      logic                           done_o,
  output      logic [rrf_pkg::DATA_W-1:0]     pop_data_o,
  output      logic [rrf_pkg::STATUS_W-1:0]   status_o,
  output      logic [rrf_pkg::COUNT_W-1:0]    item_count_o,
  output      logic [rrf_pkg::COUNT_W-1:0]    cur_capacity_o,
  output      logic [rrf_pkg::TOTAL_W-1:0]    added_total_o,
  output      logic [rrf_pkg::TOTAL_W-1:0]    removed_total_o
);

  localparam int AW = $clog2(MAX_DEPTH);
  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int DW = (HANDLE_WIDTH < rrf_pkg::DATA_W) ? HANDLE_WIDTH : rrf_pkg::DATA_W;
  localparam int InitCap = (MAX_DEPTH < rrf_pkg::INIT_CAPACITY) ?
                           MAX_DEPTH : rrf_pkg::INIT_CAPACITY;

  // advance a ring index, wrapping at the given capacity
  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] idx,
                                              input logic [CW-1:0] cap);
    logic [CW-1:0] nxt;
    nxt = CW'(idx) + CW'(1);
    return (nxt >= cap) ? '0 : AW'(nxt);
  endfunction

  logic          bank_q, bank_d;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] fill_q, fill_d, cap_q, cap_d;
  logic [rrf_pkg::TOTAL_W-1:0] push_tot_q, push_tot_d, pop_tot_q, pop_tot_d;
  logic [AW-1:0] ridx_q, ridx_d, wa_q, wa_d;
  logic [CW-1:0] rcnt_q, rcnt_d;
  logic          wv_q, wv_d;
  logic          fwd_v_q, fwd_v_d;
  logic [DW-1:0] fwd_data_q;
  logic          done_q;

  logic [DW-1:0] rdata0, rdata1, bank_rdata, head_word, wdata;
  logic [AW-1:0] raddr, waddr;
  logic          we0, we1;

  // status toward the controller
  assign sts_o.full      = (fill_q >= cap_q);
  assign sts_o.empty     = (fill_q == '0);
  assign sts_o.at_max    = (cap_q >= CW'(MAX_DEPTH));
  assign sts_o.at_min    = (cap_q <= CW'(1));
  assign sts_o.too_many  = (fill_q >= (cap_q - CW'(1)));
  assign sts_o.copy_last = (rcnt_q == fill_q);

  // store access: the active bank is read at the next head, or at the
  // copy index while compacting; compaction writes into the other bank
  assign bank_rdata = bank_q ? rdata1 : rdata0;
  assign head_word  = fwd_v_q ? fwd_data_q : bank_rdata;
  assign raddr      = cmd_i.copy_rd ? ridx_q : head_d;
  assign waddr      = cmd_i.push ? tail_q : wa_q;
  assign wdata      = cmd_i.push ? push_data_i[DW-1:0] : bank_rdata;
  assign we0        = (cmd_i.push && !bank_q) || (wv_q && bank_q);
  assign we1        = (cmd_i.push && bank_q) || (wv_q && !bank_q);
  assign fwd_v_d    = cmd_i.push && (tail_q == raddr);

  rrf_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_DEPTH)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (we0),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata0)
  );

  rrf_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_DEPTH)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata1)
  );

  // pointer, count and total updates
  always_comb begin
    bank_d     = bank_q;
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    cap_d      = cap_q;
    push_tot_d = push_tot_q;
    pop_tot_d  = pop_tot_q;
    ridx_d     = ridx_q;
    rcnt_d     = rcnt_q;
    wv_d       = cmd_i.copy_rd;
    wa_d       = AW'(rcnt_q);
    if (cmd_i.push) begin
      tail_d     = wrap_next(tail_q, cap_q);
      fill_d     = fill_q + CW'(1);
      push_tot_d = push_tot_q + rrf_pkg::TOTAL_W'(1);
    end
    if (cmd_i.pop) begin
      head_d    = wrap_next(head_q, cap_q);
      fill_d    = fill_q - CW'(1);
      pop_tot_d = pop_tot_q + rrf_pkg::TOTAL_W'(1);
    end
    if (cmd_i.copy_init) begin
      ridx_d = head_q;
      rcnt_d = '0;
    end
    if (cmd_i.copy_rd) begin
      ridx_d = wrap_next(ridx_q, cap_q);
      rcnt_d = rcnt_q + CW'(1);
    end
    if (cmd_i.commit) begin
      bank_d = ~bank_q;
      head_d = '0;
      tail_d = AW'(fill_q);
      cap_d  = cmd_i.grow ? (cap_q + CW'(1)) : (cap_q - CW'(1));
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q     <= 1'b0;
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      cap_q      <= CW'(InitCap);
      push_tot_q <= '0;
      pop_tot_q  <= '0;
      ridx_q     <= '0;
      rcnt_q     <= '0;
      wv_q       <= 1'b0;
      wa_q       <= '0;
      fwd_v_q    <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      bank_q     <= bank_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      fill_q     <= fill_d;
      cap_q      <= cap_d;
      push_tot_q <= push_tot_d;
      pop_tot_q  <= pop_tot_d;
      ridx_q     <= ridx_d;
      rcnt_q     <= rcnt_d;
      wv_q       <= wv_d;
      wa_q       <= wa_d;
      fwd_v_q    <= fwd_v_d;
      done_q     <= cmd_i.emit;
    end
  end

  // forwarded word and result registers
  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata;
    if (cmd_i.emit) begin
      pop_data_o      <= cmd_i.pop ? rrf_pkg::DATA_W'(head_word) : '0;
      status_o        <= cmd_i.status;
      item_count_o    <= rrf_pkg::COUNT_W'(fill_d);
      cur_capacity_o  <= rrf_pkg::COUNT_W'(cap_d);
      added_total_o   <= push_tot_d;
      removed_total_o <= pop_tot_d;
    end
  end

  assign done_o = done_q;

  // count never exceeds capacity
  a_fill_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cap_q)
    else $error("item count above capacity");

  // capacity stays within build limits
  a_cap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q >= CW'(1)) && (cap_q <= CW'(MAX_DEPTH)))
    else $error("capacity out of range");

  // a resize rebases the ring at slot zero
  a_commit_rebase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> (head_q == '0) && (tail_q == AW'(fill_q)) && (bank_q != $past(bank_q)))
    else $error("compaction left ring misaligned");

  // pushes never coincide with compaction writes, nor are both banks written at once
  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.push && wv_q) && !(we0 && we1))
    else $error("store write clash");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// self-checking testbench of the resizable ring fifo unit
`default_nettype none

module tb_top;

  localparam int DEPTH       = rrf_pkg::DEF_MAX_DEPTH;
  localparam int HANDLE_W    = rrf_pkg::DEF_HANDLE_WIDTH;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYC  = DEPTH + 16;
  localparam logic [rrf_pkg::DATA_W-1:0] HANDLE_MASK =
    {rrf_pkg::DATA_W{1'b1}} >> (rrf_pkg::DATA_W - HANDLE_W);

  // one result word as the block reports it
  typedef struct {
    logic [rrf_pkg::DATA_W-1:0]  pop_data;
    rrf_pkg::status_e            status;
    logic [rrf_pkg::COUNT_W-1:0] item_count;
    logic [rrf_pkg::COUNT_W-1:0] cur_capacity;
    logic [rrf_pkg::TOTAL_W-1:0] added_total;
    logic [rrf_pkg::TOTAL_W-1:0] removed_total;
  } fifo_word_t;

  // clock, reset and block inputs
  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         start       = 1'b0;
  logic [rrf_pkg::FUNC_W-1:0]   func_i      = rrf_pkg::FN_PUSH;
  logic [rrf_pkg::DATA_W-1:0]   push_data_i = '0;

  // block outputs
  logic                         busy;
  logic                         done_o;
  logic [rrf_pkg::DATA_W-1:0]   pop_data_o;
  logic [rrf_pkg::STATUS_W-1:0] status_o;
  logic [rrf_pkg::COUNT_W-1:0]  item_count_o;
  logic [rrf_pkg::COUNT_W-1:0]  cur_capacity_o;
  logic [rrf_pkg::TOTAL_W-1:0]  added_total_o;
  logic [rrf_pkg::TOTAL_W-1:0]  removed_total_o;

  // shadow copy of the queue state
  logic [rrf_pkg::DATA_W-1:0]   shadow_slots [DEPTH];
  int unsigned                  shadow_head;
  int unsigned                  shadow_tail;
  int unsigned                  shadow_fill;
  int unsigned                  shadow_cap;
  logic [rrf_pkg::TOTAL_W-1:0]  shadow_pushes;
  logic [rrf_pkg::TOTAL_W-1:0]  shadow_pops;

  fifo_word_t          awaited_words [$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count    = 0;
  int unsigned         idle_pct       = 0;

  resizable_ring_fifo_unit #(
    .MAX_DEPTH    (DEPTH),
    .HANDLE_WIDTH (HANDLE_W)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .func_i          (func_i),
    .push_data_i     (push_data_i),
    .done_o          (done_o),
    .pop_data_o      (pop_data_o),
    .status_o        (status_o),
    .item_count_o    (item_count_o),
    .cur_capacity_o  (cur_capacity_o),
    .added_total_o   (added_total_o),
    .removed_total_o (removed_total_o)
  );

  // free-running clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("resizable_ring_fifo_unit regression: fail");
      $finish;
    end
  end

  // one line per mismatch
  task automatic flag_mismatch(input string what, input logic [rrf_pkg::DATA_W-1:0] got,
                               input logic [rrf_pkg::DATA_W-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic int unsigned ring_next(input int unsigned idx, input int unsigned cap);
    return (idx + 1 >= cap) ? 0 : idx + 1;
  endfunction

  task automatic reset_shadow();
    shadow_head   = 0;
    shadow_tail   = 0;
    shadow_fill   = 0;
    shadow_cap    = (rrf_pkg::INIT_CAPACITY < DEPTH) ? rrf_pkg::INIT_CAPACITY : DEPTH;
    shadow_pushes = '0;
    shadow_pops   = '0;
    foreach (shadow_slots[i]) shadow_slots[i] = '0;
  endtask

  // move held entries so the head lands on slot 0, order kept
  task automatic rebase_slots(input int unsigned old_cap);
    logic [rrf_pkg::DATA_W-1:0] held [DEPTH];
    int unsigned                idx;
    idx = shadow_head;
    for (int i = 0; i < shadow_fill && i < DEPTH; i++) begin
      held[i] = shadow_slots[idx % DEPTH];
      idx = ring_next(idx, old_cap);
    end
    for (int i = 0; i < shadow_fill && i < DEPTH; i++) shadow_slots[i] = held[i];
    shadow_head = 0;
  endtask

  // apply one accepted command to the shadow queue and queue its result word
  task automatic advance_shadow_fifo(input rrf_pkg::func_e f,
                                     input logic [rrf_pkg::DATA_W-1:0] d);
    fifo_word_t  w;
    int unsigned cap;
    w.pop_data = '0;
    w.status   = rrf_pkg::STAT_OK;
    cap        = shadow_cap;
    case (f)
      rrf_pkg::FN_PUSH: begin
        if (shadow_fill >= cap) begin
          w.status = rrf_pkg::STAT_FULL;
        end else begin
          shadow_slots[shadow_tail % DEPTH] = d & HANDLE_MASK;
          shadow_tail = ring_next(shadow_tail, cap);
          shadow_fill++;
          shadow_pushes++;
        end
      end
      rrf_pkg::FN_POP: begin
        if (shadow_fill == 0) begin
          w.status = rrf_pkg::STAT_EMPTY;
        end else begin
          w.pop_data  = shadow_slots[shadow_head % DEPTH];
          shadow_head = ring_next(shadow_head, cap);
          shadow_fill--;
          shadow_pops++;
        end
      end
      rrf_pkg::FN_GROW: begin
        if (cap >= DEPTH) begin
          w.status = rrf_pkg::STAT_AT_MAX;
        end else begin
          rebase_slots(cap);
          shadow_cap  = cap + 1;
          shadow_tail = shadow_fill;
        end
      end
      default: begin
        if (cap <= 1) begin
          w.status = rrf_pkg::STAT_AT_MIN;
        end else if (shadow_fill >= cap - 1) begin
          w.status = rrf_pkg::STAT_TOO_MANY;
        end else begin
          rebase_slots(cap);
          shadow_cap  = cap - 1;
          shadow_tail = shadow_fill;
        end
      end
    endcase
    w.item_count    = shadow_fill[rrf_pkg::COUNT_W-1:0];
    w.cur_capacity  = shadow_cap[rrf_pkg::COUNT_W-1:0];
    w.added_total   = shadow_pushes;
    w.removed_total = shadow_pops;
    awaited_words.push_back(w);
  endtask

  // offer one command word, with a random idle gap first
  task automatic send_word(input rrf_pkg::func_e f, input logic [rrf_pkg::DATA_W-1:0] d);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start       <= 1'b1;
    func_i      <= f;
    push_data_i <= d;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    advance_shadow_fifo(f, d);
  endtask

  // drop start, wait for every awaited word, then let the block settle
  task automatic wait_drained();
    start <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  function automatic logic [rrf_pkg::DATA_W-1:0] pick_handle();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return $urandom();
  endfunction

  // compare each result word with the oldest awaited one
  always @(posedge clk_i) begin : check_words
    fifo_word_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (awaited_words.size() == 0) begin
        flag_mismatch("unexpected word, status", rrf_pkg::DATA_W'(status_o), '0);
      end else begin
        want = awaited_words.pop_front();
        if (pop_data_o !== want.pop_data)
          flag_mismatch("pop_data", pop_data_o, want.pop_data);
        if (status_o !== want.status)
          flag_mismatch("status", rrf_pkg::DATA_W'(status_o),
                        rrf_pkg::DATA_W'(want.status));
        if (item_count_o !== want.item_count)
          flag_mismatch("item_count", rrf_pkg::DATA_W'(item_count_o),
                        rrf_pkg::DATA_W'(want.item_count));
        if (cur_capacity_o !== want.cur_capacity)
          flag_mismatch("cur_capacity", rrf_pkg::DATA_W'(cur_capacity_o),
                        rrf_pkg::DATA_W'(want.cur_capacity));
        if (added_total_o !== want.added_total)
          flag_mismatch("added_total", added_total_o, want.added_total);
        if (removed_total_o !== want.removed_total)
          flag_mismatch("removed_total", removed_total_o, want.removed_total);
      end
    end
  end

  // empty pop, full push, shrink with too many, resize over a wrapped ring
  task automatic test_directed_cases();
    send_word(rrf_pkg::FN_POP, '1);
    send_word(rrf_pkg::FN_SHRINK, $urandom());
    send_word(rrf_pkg::FN_GROW, $urandom());
    send_word(rrf_pkg::FN_PUSH, 32'hFFFF_FFFF);
    send_word(rrf_pkg::FN_PUSH, 32'h0000_0000);
    send_word(rrf_pkg::FN_PUSH, 32'hAAAA_AAAA);
    send_word(rrf_pkg::FN_PUSH, 32'h5555_5555);
    repeat (4) send_word(rrf_pkg::FN_PUSH, $urandom());
    send_word(rrf_pkg::FN_PUSH, $urandom());
    send_word(rrf_pkg::FN_SHRINK, $urandom());
    send_word(rrf_pkg::FN_POP, $urandom());
    send_word(rrf_pkg::FN_POP, $urandom());
    send_word(rrf_pkg::FN_PUSH, $urandom());
    send_word(rrf_pkg::FN_PUSH, $urandom());
    send_word(rrf_pkg::FN_GROW, $urandom());
    send_word(rrf_pkg::FN_POP, $urandom());
    send_word(rrf_pkg::FN_SHRINK, $urandom());
    while (shadow_fill != 0) send_word(rrf_pkg::FN_POP, $urandom());
    send_word(rrf_pkg::FN_POP, $urandom());
  endtask

  // walk capacity down to one and up to the build depth
  task automatic test_capacity_extremes();
    while (shadow_fill != 0) send_word(rrf_pkg::FN_POP, $urandom());
    while (shadow_cap > 1) send_word(rrf_pkg::FN_SHRINK, $urandom());
    send_word(rrf_pkg::FN_SHRINK, $urandom());
    send_word(rrf_pkg::FN_PUSH, pick_handle());
    send_word(rrf_pkg::FN_PUSH, pick_handle());
    send_word(rrf_pkg::FN_SHRINK, $urandom());
    send_word(rrf_pkg::FN_GROW, $urandom());
    send_word(rrf_pkg::FN_POP, $urandom());
    // grow with entries moving through the ring
    while (shadow_cap < DEPTH) begin
      if ($urandom_range(99) < 60) send_word(rrf_pkg::FN_PUSH, pick_handle());
      if ($urandom_range(99) < 20) send_word(rrf_pkg::FN_POP, $urandom());
      send_word(rrf_pkg::FN_GROW, $urandom());
    end
    send_word(rrf_pkg::FN_GROW, $urandom());
    while (shadow_fill < shadow_cap) send_word(rrf_pkg::FN_PUSH, pick_handle());
    send_word(rrf_pkg::FN_PUSH, pick_handle());
    repeat (3) send_word(rrf_pkg::FN_POP, $urandom());
    repeat (3) send_word(rrf_pkg::FN_PUSH, pick_handle());
    send_word(rrf_pkg::FN_SHRINK, $urandom());
    // shrink back down, popping where the count blocks it
    while (shadow_cap > rrf_pkg::INIT_CAPACITY) begin
      if (shadow_fill >= shadow_cap - 1) send_word(rrf_pkg::FN_POP, $urandom());
      else send_word(rrf_pkg::FN_SHRINK, $urandom());
    end
    while (shadow_fill != 0) send_word(rrf_pkg::FN_POP, $urandom());
  endtask

  // bursts of fill or drain bias with random resizes mixed in
  task automatic test_random_traffic(input int unsigned count);
    int unsigned fill_bias;
    int unsigned r;
    fill_bias = 50;
    for (int unsigned n = 0; n < count; n++) begin
      if (n % 16 == 0) fill_bias = $urandom_range(90, 10);
      r = $urandom_range(99);
      if (r < 10) send_word(rrf_pkg::FN_GROW, $urandom());
      else if (r < 21) send_word(rrf_pkg::FN_SHRINK, $urandom());
      else if ($urandom_range(99) < fill_bias) send_word(rrf_pkg::FN_PUSH, pick_handle());
      else send_word(rrf_pkg::FN_POP, $urandom());
    end
  endtask

  // test sequence
  initial begin
    reset_shadow();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 24;
    test_directed_cases();
    test_capacity_extremes();
    test_random_traffic(30);
    wait_drained();

    idle_pct = 64;
    test_random_traffic(30);
    wait_drained();

    idle_pct = 0;
    test_random_traffic(30);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("resizable_ring_fifo_unit regression: pass");
    end else begin
      $display("resizable_ring_fifo_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
